[src/brg_pkg.sv]
`default_nettype none

package brg_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int FRAME_BITS = 10;
  localparam int OP_W       = 3;
  localparam int W          = FRAC_BITS + 1;
  localparam int DEN_W      = (FRAC_BITS + 2 > FRAME_BITS) ? FRAC_BITS + 2 : FRAME_BITS;
  localparam int REM_W      = DEN_W + 1;
  localparam int DIV_STEPS  = W;
  localparam int CNT_W      = $clog2(DIV_STEPS);

  localparam logic [W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef logic [W-1:0] weight_t;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_REMOVE = 3'd2,
    OP_STOP   = 3'd3,
    OP_RESET  = 3'd4
  } opcode_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_TICK,
    CMD_START,
    CMD_REMOVE,
    CMD_STOP,
    CMD_WRESET,
    CMD_SQUARE,
    CMD_LEVEL,
    CMD_DIV_SEL,
    CMD_SEL,
    CMD_ANM,
    CMD_STEP
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_LEVEL,
    ST_DENOM,
    ST_WAIT_SEL,
    ST_WAIT_ANM,
    ST_DIV_STEP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    cmd_e op;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic level_zero;
    logic wrap;
    logic frames_zero;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

[src/brg_if.sv]
`default_nettype none

interface brg_in_if;
  logic                            valid;
  logic                            ready;
  logic [brg_pkg::OP_W-1:0]        opcode;
  logic [brg_pkg::FRAME_BITS-1:0]  blend_frames;

  modport source (output valid, output opcode, output blend_frames, input ready);
  modport sink   (input valid, input opcode, input blend_frames, output ready);
endinterface

interface brg_out_if;
  logic                   valid;
  logic                   ready;
  logic                   active;
  logic [brg_pkg::W-1:0]  select_weight;
  logic [brg_pkg::W-1:0]  anim_weight;
  logic [brg_pkg::W-1:0]  slerp_weight;
  logic                   updated_flag;
  logic                   off_flag;

  modport source (output valid, output active, output select_weight, output anim_weight,
                  output slerp_weight, output updated_flag, output off_flag, input ready);
  modport sink   (input valid, input active, input select_weight, input anim_weight,
                  input slerp_weight, input updated_flag, input off_flag, output ready);
endinterface

`default_nettype wire

[src/brg_div.sv]
`default_nettype none

module brg_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [brg_pkg::DEN_W-1:0] x_i,
  input  wire logic [brg_pkg::DEN_W-1:0] den_i,
  output logic                           done_o,
  output logic [brg_pkg::W-1:0]          quot_o
);
  import brg_pkg::*;

  localparam logic [CNT_W-1:0] LastCnt = CNT_W'(DIV_STEPS - 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [REM_W-1:0] r_q, r_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [W-1:0]     q_q, q_d;
  logic             ge;
  logic [REM_W-1:0] diff;
  logic [DEN_W-1:0] rem;
  logic             last;

  // one quotient bit per cycle, restoring
  always_comb begin
    ge     = r_q >= {1'b0, den_q};
    diff   = r_q - {1'b0, den_q};
    rem    = ge ? diff[DEN_W-1:0] : r_q[DEN_W-1:0];
    last   = busy_q && (cnt_q == LastCnt);
    done_o = last;
    quot_o = {q_q[W-2:0], ge};

    busy_d = busy_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    den_d  = den_q;
    q_d    = q_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = {1'b0, x_i};
      den_d  = den_i;
      q_d    = '0;
    end else if (busy_q) begin
      r_d   = {rem, 1'b0};
      q_d   = {q_q[W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q   <= r_d;
    den_q <= den_d;
    q_q   <= q_d;
  end

endmodule

`default_nettype wire

[src/brg_dp.sv]
`default_nettype none

module brg_dp (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [brg_pkg::FRAME_BITS-1:0] frames_i,
  input  wire brg_pkg::dp_cmd_t               cmd_i,
  output brg_pkg::dp_status_t                 st_o,
  output logic                                active_o,
  output logic [brg_pkg::W-1:0]               select_weight_o,
  output logic [brg_pkg::W-1:0]               anim_weight_o,
  output logic [brg_pkg::W-1:0]               slerp_weight_o,
  output logic                                updated_flag_o,
  output logic                                off_flag_o
);
  import brg_pkg::*;

  weight_t level_q, level_d;
  weight_t progress_q, progress_d;
  weight_t step_q, step_d;
  weight_t sel_q, sel_d;
  weight_t anm_q, anm_d;
  weight_t slerp_q, slerp_d;
  logic    upd_q, upd_d;
  logic    off_q, off_d;
  weight_t d_q, d_d;
  weight_t s_q, s_d;
  logic [DEN_W-1:0] den_q, den_d;

  logic [W:0]             sum;
  logic                   wrap;
  logic [2*FRAC_BITS-1:0] sq;
  logic [2*W-1:0]         lprod;
  weight_t                s_calc;
  logic [DEN_W-1:0]       den_calc;
  logic                   div_start;
  logic [DEN_W-1:0]       div_x;
  logic [DEN_W-1:0]       div_den;
  logic                   div_done;
  weight_t                quot;

  brg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .x_i     (div_x),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    sum      = {1'b0, progress_q} + {1'b0, step_q};
    wrap     = sum >= {1'b0, ONE};
    sq       = progress_q[FRAC_BITS-1:0] * progress_q[FRAC_BITS-1:0];
    lprod    = level_q * d_q;
    s_calc   = ONE - level_q;
    den_calc = DEN_W'(d_q) + DEN_W'(s_calc);

    st_o.level_zero  = (level_q == '0);
    st_o.wrap        = wrap;
    st_o.frames_zero = (frames_i == '0);
    st_o.div_done    = div_done;

    div_start = 1'b0;
    div_x     = DEN_W'(d_q);
    div_den   = den_calc;

    level_d    = level_q;
    progress_d = progress_q;
    step_d     = step_q;
    sel_d      = sel_q;
    anm_d      = anm_q;
    slerp_d    = slerp_q;
    upd_d      = upd_q;
    off_d      = off_q;
    d_d        = d_q;
    s_d        = s_q;
    den_d      = den_q;

    unique case (cmd_i.op)
      CMD_TICK: begin
        if (wrap) begin
          level_d    = '0;
          progress_d = ONE;
          sel_d      = '0;
          anm_d      = ONE;
          slerp_d    = ONE;
        end else begin
          progress_d = sum[W-1:0];
          upd_d      = 1'b1;
        end
      end
      CMD_START: begin
        if (frames_i == '0) begin
          level_d    = '0;
          progress_d = ONE;
          sel_d      = '0;
          anm_d      = ONE;
          slerp_d    = ONE;
        end else begin
          level_d    = ONE;
          progress_d = '0;
          sel_d      = ONE;
          anm_d      = '0;
          slerp_d    = '0;
          upd_d      = 1'b1;
          div_start  = 1'b1;
          div_x      = DEN_W'(1);
          div_den    = DEN_W'(frames_i);
        end
      end
      CMD_REMOVE: begin
        off_d      = 1'b0;
        level_d    = '0;
        progress_d = ONE;
        sel_d      = '0;
        anm_d      = ONE;
        slerp_d    = ONE;
      end
      CMD_STOP: begin
        off_d = 1'b1;
        upd_d = 1'b0;
      end
      CMD_WRESET: begin
        level_d    = '0;
        progress_d = ONE;
        sel_d      = '0;
        anm_d      = ONE;
        slerp_d    = ONE;
      end
      CMD_SQUARE: begin
        d_d = ONE - W'(sq[2*FRAC_BITS-1:FRAC_BITS]);
      end
      CMD_LEVEL: begin
        level_d = lprod[FRAC_BITS+W-1:FRAC_BITS];
      end
      CMD_DIV_SEL: begin
        s_d       = s_calc;
        den_d     = den_calc;
        div_start = 1'b1;
      end
      CMD_SEL: begin
        sel_d     = quot;
        div_start = 1'b1;
        div_x     = DEN_W'(s_q);
        div_den   = den_q;
      end
      CMD_ANM: begin
        anm_d   = quot;
        slerp_d = quot;
      end
      CMD_STEP: begin
        step_d = quot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q    <= '0;
      progress_q <= ONE;
      step_q     <= '0;
      sel_q      <= '0;
      anm_q      <= ONE;
      slerp_q    <= ONE;
      upd_q      <= 1'b0;
      off_q      <= 1'b0;
    end else begin
      level_q    <= level_d;
      progress_q <= progress_d;
      step_q     <= step_d;
      sel_q      <= sel_d;
      anm_q      <= anm_d;
      slerp_q    <= slerp_d;
      upd_q      <= upd_d;
      off_q      <= off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    d_q   <= d_d;
    s_q   <= s_d;
    den_q <= den_d;
    if (cmd_i.load_out) begin
      active_o        <= (level_q != '0);
      select_weight_o <= sel_q;
      anim_weight_o   <= anm_q;
      slerp_weight_o  <= slerp_q;
      updated_flag_o  <= upd_q;
      off_flag_o      <= off_q;
    end
  end

`ifndef ASSERT_OFF
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= ONE)
    else $error("level above one");
  a_square_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_SQUARE) |-> (progress_q < ONE))
    else $error("square with progress at or above one");
`endif

endmodule

`default_nettype wire

[src/brg_ctrl.sv]
`default_nettype none

module brg_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  input  wire logic [brg_pkg::OP_W-1:0] opcode_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  input  wire brg_pkg::dp_status_t      st_i,
  output brg_pkg::dp_cmd_t              cmd_o
);
  import brg_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = CMD_NONE;
    cmd_o.load_out = 1'b0;
    in_ready_o    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = ST_EMIT;
          unique case (opcode_i)
            OP_TICK: begin
              if (!st_i.level_zero) begin
                cmd_o.op = CMD_TICK;
                if (!st_i.wrap) begin
                  state_d = ST_SQUARE;
                end
              end
            end
            OP_START: begin
              cmd_o.op = CMD_START;
              if (!st_i.frames_zero) begin
                state_d = ST_DIV_STEP;
              end
            end
            OP_REMOVE: cmd_o.op = CMD_REMOVE;
            OP_STOP:   cmd_o.op = CMD_STOP;
            OP_RESET:  cmd_o.op = CMD_WRESET;
            default: begin
            end
          endcase
        end
      end
      ST_SQUARE: begin
        cmd_o.op = CMD_SQUARE;
        state_d  = ST_LEVEL;
      end
      ST_LEVEL: begin
        cmd_o.op = CMD_LEVEL;
        state_d  = ST_DENOM;
      end
      ST_DENOM: begin
        cmd_o.op = CMD_DIV_SEL;
        state_d  = ST_WAIT_SEL;
      end
      ST_WAIT_SEL: begin
        if (st_i.div_done) begin
          cmd_o.op = CMD_SEL;
          state_d  = ST_WAIT_ANM;
        end
      end
      ST_WAIT_ANM: begin
        if (st_i.div_done) begin
          cmd_o.op = CMD_ANM;
          state_d  = ST_EMIT;
        end
      end
      ST_DIV_STEP: begin
        if (st_i.div_done) begin
          cmd_o.op = CMD_STEP;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
    endcase

    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && cmd_o.load_out) |=> out_valid_q)
    else $error("result load without valid");
  a_idle_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !st_i.div_done)
    else $error("divider finished while idle");
`endif

endmodule

`default_nettype wire

[src/blend_ratio_generator_top.sv]
`default_nettype none

// crossfade weight generator: opcodes tick, start, remove, stop updates and reset weights
// 16-fraction-bit weights, one result item per input item. remove, stop, reset, unused
// opcodes, idle ticks and ending ticks go straight to emit; start with a nonzero frame
// count waits for the divider to give the step size; a tick during a blend steps through
// square, level and denominator and then runs the serial divider, one quotient bit per
// cycle over 17 bits, twice for the two weights. one item is in work at a time; the next
// item is taken while the previous result still waits in the output register.
module blend_ratio_generator_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  brg_in_if.sink    in_i,
  brg_out_if.source out_o
);
  import brg_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  brg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .opcode_i    (in_i.opcode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  brg_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .frames_i        (in_i.blend_frames),
    .cmd_i           (cmd),
    .st_o            (st),
    .active_o        (out_o.active),
    .select_weight_o (out_o.select_weight),
    .anim_weight_o   (out_o.anim_weight),
    .slerp_weight_o  (out_o.slerp_weight),
    .updated_flag_o  (out_o.updated_flag),
    .off_flag_o      (out_o.off_flag)
  );

endmodule

`default_nettype wire

[tb/blend_ratio_generator_top_test.sv]
`timescale 1ns / 100ps

module blend_ratio_generator_top_test;
  import brg_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic    active;
    weight_t select_w;
    weight_t anim_w;
    weight_t slerp_w;
    logic    updated;
    logic    off;
  } blend_result_t;

  logic clk = 1'b0;
  logic rst_n;

  brg_in_if  in_if ();
  brg_out_if out_if ();

  blend_ratio_generator_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // blend state tracked alongside the block
  weight_t blend_level;
  weight_t blend_progress;
  weight_t blend_step;
  weight_t sel_w;
  weight_t anm_w;
  weight_t slerp_w;
  logic    upd_state;
  logic    off_state;

  blend_result_t pending_weights[$];
  int unsigned   mismatch_count = 0;
  int unsigned   busy_items = 0;
  int unsigned   send_idle_pct;
  int unsigned   recv_idle_pct;
  int unsigned   hold_request = 0;

  function automatic void clear_weights();
    blend_level    = '0;
    blend_progress = ONE;
    sel_w          = '0;
    anm_w          = ONE;
    slerp_w        = ONE;
  endfunction

  function automatic blend_result_t advance_blend(logic [OP_W-1:0] op,
                                                  logic [FRAME_BITS-1:0] frames);
    logic [63:0]   sum;
    logic [63:0]   p2;
    logic [63:0]   d;
    logic [63:0]   s;
    logic [63:0]   den;
    blend_result_t res;
    case (op)
      OP_TICK: begin
        if (blend_level != 0) begin
          sum = 64'(blend_progress) + 64'(blend_step);
          if (sum >= 64'(ONE)) begin
            clear_weights();
          end else begin
            blend_progress = weight_t'(sum);
            upd_state      = 1'b1;
            p2             = (64'(blend_progress) * 64'(blend_progress)) >> FRAC_BITS;
            d              = 64'(ONE) - p2;
            blend_level    = weight_t'((64'(blend_level) * d) >> FRAC_BITS);
            s              = 64'(ONE) - 64'(blend_level);
            den            = d + s;
            sel_w          = weight_t'((d << FRAC_BITS) / den);
            anm_w          = weight_t'((s << FRAC_BITS) / den);
            slerp_w        = anm_w;
          end
        end
      end
      OP_START: begin
        if (frames == 0) begin
          clear_weights();
        end else begin
          blend_level    = ONE;
          blend_progress = '0;
          sel_w          = ONE;
          anm_w          = '0;
          slerp_w        = '0;
          upd_state      = 1'b1;
          blend_step     = weight_t'(64'(ONE) / 64'(frames));
        end
      end
      OP_REMOVE: begin
        off_state = 1'b0;
        clear_weights();
      end
      OP_STOP: begin
        off_state = 1'b1;
        upd_state = 1'b0;
      end
      OP_RESET: begin
        clear_weights();
      end
      default: begin
      end
    endcase
    res.active   = (blend_level != 0);
    res.select_w = sel_w;
    res.anim_w   = anm_w;
    res.slerp_w  = slerp_w;
    res.updated  = upd_state;
    res.off      = off_state;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] error: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [W-1:0] got, logic [W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic send_item(logic [OP_W-1:0] op, logic [FRAME_BITS-1:0] frames);
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.blend_frames <= frames;
    do @(posedge clk); while (!in_if.ready);
    if (!(op > OP_RESET || (op == OP_TICK && blend_level == 0))) begin
      busy_items++;
    end
    pending_weights.push_back(advance_blend(op, frames));
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (pending_weights.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_item(OP_TICK, '0);
    send_item(OP_STOP, '1);
    // one-frame blend ends on its first tick
    send_item(OP_START, FRAME_BITS'(1));
    send_item(OP_TICK, '1);
    send_item(OP_START, FRAME_BITS'(2));
    repeat (2) send_item(OP_TICK, '0);
    // level truncates to zero before progress wraps
    send_item(OP_START, FRAME_BITS'(3));
    repeat (4) send_item(OP_TICK, '0);
    send_item(OP_START, '1);
    send_item(OP_TICK, '0);
    send_item(OP_STOP, '0);
    send_item(OP_TICK, '1);
    send_item(OP_REMOVE, '1);
    send_item(OP_START, FRAME_BITS'(512));
    send_item(OP_TICK, '0);
    send_item(OP_RESET, '1);
    send_item(OP_START, '0);
    for (int op = OP_RESET + 1; op < 2 ** OP_W; op++) begin
      send_item(op[OP_W-1:0], '1);
    end
  endtask

  task automatic test_output_stall();
    hold_request = HOLD_CYCLES;
    send_item(OP_START, FRAME_BITS'(4));
    repeat (6) send_item(OP_TICK, FRAME_BITS'($urandom));
    send_item(OP_REMOVE, '0);
    send_item(OP_START, FRAME_BITS'(7));
    repeat (8) send_item(OP_TICK, FRAME_BITS'($urandom));
    drain_results();
  endtask

  task automatic test_random_traffic(int unsigned target);
    int unsigned first_count;
    int unsigned frames;
    int unsigned cap;
    int unsigned ticks;
    first_count = busy_items;
    while (busy_items - first_count < target) begin
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(9))
          0:       frames = $urandom_range(1023, 201);
          1, 2:    frames = $urandom_range(200, 17);
          default: frames = $urandom_range(16, 1);
        endcase
        send_item(OP_START, frames[FRAME_BITS-1:0]);
        cap   = (frames + 3 < 40) ? frames + 3 : 40;
        ticks = $urandom_range(cap, 1);
        repeat (ticks) begin
          if ($urandom_range(99) < 6) begin
            send_item(OP_W'($urandom_range(2 ** OP_W - 1)), FRAME_BITS'($urandom));
          end
          send_item(OP_TICK, FRAME_BITS'($urandom));
        end
      end else begin
        frames = ($urandom_range(3) == 0) ? 0 : $urandom_range(2 ** FRAME_BITS - 1);
        send_item(OP_W'($urandom_range(2 ** OP_W - 1)), frames[FRAME_BITS-1:0]);
      end
    end
  endtask

  // result receiver with random stalls and long hold-offs
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin : check_item
    blend_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_weights.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_weights.pop_front();
        check_field("active", W'(out_if.active), W'(want.active));
        check_field("select_weight", out_if.select_weight, want.select_w);
        check_field("anim_weight", out_if.anim_weight, want.anim_w);
        check_field("slerp_weight", out_if.slerp_weight, want.slerp_w);
        check_field("updated_flag", W'(out_if.updated_flag), W'(want.updated));
        check_field("off_flag", W'(out_if.off_flag), W'(want.off));
      end
    end
  end

  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n              <= 1'b0;
    in_if.valid        <= 1'b0;
    in_if.opcode       <= OP_TICK;
    in_if.blend_frames <= '0;
    clear_weights();
    blend_step    = '0;
    upd_state     = 1'b0;
    off_state     = 1'b0;
    send_idle_pct = 29;
    recv_idle_pct = 62;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_output_stall();
    test_random_traffic(370);
    send_idle_pct = 62;
    recv_idle_pct = 29;
    test_random_traffic(370);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(370);
    drain_results();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
